>>> rtl/rtmp_media_chunk_framer_assert.svh
// ---------------------------------------------------------------------------
// RTMP media chunk framer assertion macros
// Shared concurrent assertion forms for the framer's checker.
// ---------------------------------------------------------------------------
`ifndef RTMP_MEDIA_CHUNK_FRAMER_ASSERT_SVH
`define RTMP_MEDIA_CHUNK_FRAMER_ASSERT_SVH

// Property checked only while reset is released.
`define RMCF_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Property checked at every edge, including during reset.
`define RMCF_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/rmcf_pkg.sv
// ---------------------------------------------------------------------------
// RTMP media chunk framer package
// Shared types, header constants and register indexes of the framer.
// ---------------------------------------------------------------------------
package rmcf_pkg;

    localparam int unsigned MAX_BURST = 18;
    localparam int unsigned COUNT_W   = 5;

    localparam logic [4:0] VIDEO_BURST_LEN = 5'd18;
    localparam logic [4:0] AUDIO_BURST_LEN = 5'd11;

    localparam logic [7:0] VIDEO_CHUNK_HDR = 8'd73;
    localparam logic [7:0] AUDIO_CHUNK_HDR = 8'd72;
    localparam logic [7:0] VIDEO_SEPARATOR = 8'd201;
    localparam logic [7:0] AUDIO_SEPARATOR = 8'd200;
    localparam logic [7:0] VIDEO_MSG_TYPE  = 8'd9;
    localparam logic [7:0] AUDIO_MSG_TYPE  = 8'd8;
    localparam logic [7:0] VIDEO_KEY_FLAGS = 8'd23;
    localparam logic [7:0] VIDEO_INTER_FLAGS = 8'd39;
    localparam logic [7:0] AAC_FORMAT_BASE = 8'd172;
    localparam logic [7:0] AVC_NALU_PACKET = 8'd1;
    localparam logic [7:0] AAC_RAW_PACKET  = 8'd1;

    localparam logic [4:0] NAL_IDR = 5'd5;
    localparam logic [4:0] NAL_SPS = 5'd7;
    localparam logic [4:0] NAL_PPS = 5'd8;

    localparam logic [15:0] CHUNK_LEN_MIN    = 16'd16;
    localparam logic [15:0] CHUNK_LEN_RESET  = 16'd4096;
    localparam logic [15:0] VIDEO_HDR_PAYLOAD = 16'd10;
    localparam logic [15:0] AUDIO_HDR_PAYLOAD = 16'd3;
    localparam logic [23:0] VIDEO_LEN_EXTRA  = 24'd9;
    localparam logic [23:0] AUDIO_LEN_EXTRA  = 24'd2;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_CHUNK_LEN    = 2'd0,
        CFG_AUDIO_HEADER = 2'd1,
        CFG_AUDIO_STEREO = 2'd2,
        CFG_AUDIO_16BIT  = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic        is_video;
        logic        first_byte;
        logic [7:0]  data_byte;
        logic [23:0] frame_length;
        logic [31:0] pts;
        logic [31:0] dts;
    } item_t;

    typedef logic [MAX_BURST-1:0][7:0] burst_bytes_t;

    typedef struct packed {
        burst_bytes_t       bytes;
        logic [COUNT_W-1:0] count;
    } burst_t;

    typedef struct packed {
        logic                   wr_en;
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  wdata;
    } cfg_write_t;

endpackage

>>> rtl/rmcf_ingest.sv
// ---------------------------------------------------------------------------
// RTMP media chunk framer input stage
// Registers one input transaction and holds it until the framer takes it.
// ---------------------------------------------------------------------------
module rmcf_ingest (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [95:0]     s_tdata,
    input  logic [1:0]      s_tuser,
    input  logic            take,
    output logic            item_valid,
    output rmcf_pkg::item_t item
);

    logic            item_valid_reg;
    rmcf_pkg::item_t item_reg;

    assign s_tready   = !item_valid_reg || take;
    assign item_valid = item_valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            item_valid_reg <= 1'b1;
        end else if (take) begin
            item_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.is_video     <= s_tuser[0];
            item_reg.first_byte   <= s_tuser[1];
            item_reg.data_byte    <= s_tdata[7:0];
            item_reg.frame_length <= s_tdata[31:8];
            item_reg.pts          <= s_tdata[63:32];
            item_reg.dts          <= s_tdata[95:64];
        end
    end

endmodule

>>> rtl/rmcf_framer.sv
// ---------------------------------------------------------------------------
// RTMP media chunk framer core
// Tracks stream state and builds the byte burst that one input causes.
// ---------------------------------------------------------------------------
module rmcf_framer (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  rmcf_pkg::cfg_write_t cfg,
    input  logic                 item_valid,
    input  rmcf_pkg::item_t      item,
    input  logic                 ser_ready,
    output logic                 take,
    output rmcf_pkg::burst_t     burst
);

    logic [15:0] chunk_len_reg;
    logic        audio_header_present_reg;
    logic        audio_stereo_reg;
    logic        audio_16bit_reg;

    logic [23:0] video_last_ts_reg, video_last_ts_next;
    logic [23:0] audio_last_ts_reg, audio_last_ts_next;
    logic        video_started_reg, video_started_next;
    logic        audio_started_reg, audio_started_next;
    logic        sps_seen_reg, sps_seen_next;
    logic        pps_seen_reg, pps_seen_next;
    logic        frame_mode_reg, frame_mode_next;
    logic        frame_is_video_reg, frame_is_video_next;
    logic [15:0] chunk_left_reg, chunk_left_next;
    logic [23:0] frame_left_reg, frame_left_next;

    logic [15:0] eff_chunk;
    logic [23:0] len_eff;
    logic [4:0]  nal_type;
    logic        video_go;
    logic        audio_go;
    logic [23:0] video_delta;
    logic [23:0] audio_delta;
    logic [23:0] video_msg_len;
    logic [23:0] audio_msg_len;
    logic [23:0] cts;
    logic [7:0]  aac_format;
    logic [15:0] chunk_base;

    assign take = item_valid && ser_ready;

    assign eff_chunk  = (chunk_len_reg < rmcf_pkg::CHUNK_LEN_MIN) ?
                        rmcf_pkg::CHUNK_LEN_MIN : chunk_len_reg;
    assign len_eff    = (item.frame_length == 24'd0) ? 24'd1 : item.frame_length;
    assign nal_type   = item.data_byte[4:0];
    assign video_go   = video_started_reg || (sps_seen_reg && pps_seen_reg);
    assign audio_go   = audio_started_reg || audio_header_present_reg;
    assign video_delta = video_started_reg ? (item.dts[23:0] - video_last_ts_reg) : 24'd0;
    assign audio_delta = audio_started_reg ? (item.pts[23:0] - audio_last_ts_reg) : 24'd0;
    assign video_msg_len = len_eff + rmcf_pkg::VIDEO_LEN_EXTRA;
    assign audio_msg_len = len_eff + rmcf_pkg::AUDIO_LEN_EXTRA;
    assign cts        = item.pts[23:0] - item.dts[23:0];
    assign aac_format = rmcf_pkg::AAC_FORMAT_BASE |
                        {6'd0, audio_16bit_reg, audio_stereo_reg};
    assign chunk_base = (chunk_left_reg == 16'd0) ? eff_chunk : chunk_left_reg;

    always_comb begin
        video_last_ts_next  = video_last_ts_reg;
        audio_last_ts_next  = audio_last_ts_reg;
        video_started_next  = video_started_reg;
        audio_started_next  = audio_started_reg;
        sps_seen_next       = sps_seen_reg;
        pps_seen_next       = pps_seen_reg;
        frame_mode_next     = frame_mode_reg;
        frame_is_video_next = frame_is_video_reg;
        chunk_left_next     = chunk_left_reg;
        frame_left_next     = frame_left_reg;
        burst.bytes         = '0;
        burst.count         = '0;

        if (item.first_byte) begin
            frame_mode_next     = 1'b0;
            frame_left_next     = 24'd0;
            chunk_left_next     = 16'd0;
            frame_is_video_next = item.is_video;
            if (item.is_video) begin
                if (nal_type == rmcf_pkg::NAL_SPS) begin
                    sps_seen_next = 1'b1;
                end else if (nal_type == rmcf_pkg::NAL_PPS) begin
                    pps_seen_next = 1'b1;
                end else if (video_go) begin
                    video_started_next = 1'b1;
                    video_last_ts_next = item.dts[23:0];
                    burst.bytes[0]  = rmcf_pkg::VIDEO_CHUNK_HDR;
                    burst.bytes[1]  = video_delta[23:16];
                    burst.bytes[2]  = video_delta[15:8];
                    burst.bytes[3]  = video_delta[7:0];
                    burst.bytes[4]  = video_msg_len[23:16];
                    burst.bytes[5]  = video_msg_len[15:8];
                    burst.bytes[6]  = video_msg_len[7:0];
                    burst.bytes[7]  = rmcf_pkg::VIDEO_MSG_TYPE;
                    burst.bytes[8]  = (nal_type == rmcf_pkg::NAL_IDR) ?
                                      rmcf_pkg::VIDEO_KEY_FLAGS :
                                      rmcf_pkg::VIDEO_INTER_FLAGS;
                    burst.bytes[9]  = rmcf_pkg::AVC_NALU_PACKET;
                    burst.bytes[10] = cts[23:16];
                    burst.bytes[11] = cts[15:8];
                    burst.bytes[12] = cts[7:0];
                    burst.bytes[13] = 8'd0;
                    burst.bytes[14] = len_eff[23:16];
                    burst.bytes[15] = len_eff[15:8];
                    burst.bytes[16] = len_eff[7:0];
                    burst.bytes[17] = item.data_byte;
                    burst.count     = rmcf_pkg::VIDEO_BURST_LEN;
                    frame_mode_next = 1'b1;
                    frame_left_next = len_eff - 24'd1;
                    chunk_left_next = eff_chunk - rmcf_pkg::VIDEO_HDR_PAYLOAD;
                end
            end else if (audio_go) begin
                audio_started_next = 1'b1;
                audio_last_ts_next = item.pts[23:0];
                burst.bytes[0]  = rmcf_pkg::AUDIO_CHUNK_HDR;
                burst.bytes[1]  = audio_delta[23:16];
                burst.bytes[2]  = audio_delta[15:8];
                burst.bytes[3]  = audio_delta[7:0];
                burst.bytes[4]  = audio_msg_len[23:16];
                burst.bytes[5]  = audio_msg_len[15:8];
                burst.bytes[6]  = audio_msg_len[7:0];
                burst.bytes[7]  = rmcf_pkg::AUDIO_MSG_TYPE;
                burst.bytes[8]  = aac_format;
                burst.bytes[9]  = rmcf_pkg::AAC_RAW_PACKET;
                burst.bytes[10] = item.data_byte;
                burst.count     = rmcf_pkg::AUDIO_BURST_LEN;
                frame_mode_next = 1'b1;
                frame_left_next = len_eff - 24'd1;
                chunk_left_next = eff_chunk - rmcf_pkg::AUDIO_HDR_PAYLOAD;
            end
        end else if (frame_mode_reg && (frame_left_reg != 24'd0)) begin
            if (chunk_left_reg == 16'd0) begin
                burst.bytes[0] = frame_is_video_reg ? rmcf_pkg::VIDEO_SEPARATOR :
                                                      rmcf_pkg::AUDIO_SEPARATOR;
                burst.bytes[1] = item.data_byte;
                burst.count    = 5'd2;
            end else begin
                burst.bytes[0] = item.data_byte;
                burst.count    = 5'd1;
            end
            chunk_left_next = chunk_base - 16'd1;
            frame_left_next = frame_left_reg - 24'd1;
            frame_mode_next = (frame_left_reg != 24'd1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chunk_len_reg            <= rmcf_pkg::CHUNK_LEN_RESET;
            audio_header_present_reg <= 1'b0;
            audio_stereo_reg         <= 1'b1;
            audio_16bit_reg          <= 1'b1;
        end else if (cfg.wr_en) begin
            unique case (rmcf_pkg::cfg_index_t'(cfg.index))
                rmcf_pkg::CFG_CHUNK_LEN:    chunk_len_reg            <= cfg.wdata;
                rmcf_pkg::CFG_AUDIO_HEADER: audio_header_present_reg <= cfg.wdata[0];
                rmcf_pkg::CFG_AUDIO_STEREO: audio_stereo_reg         <= cfg.wdata[0];
                rmcf_pkg::CFG_AUDIO_16BIT:  audio_16bit_reg          <= cfg.wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            video_last_ts_reg  <= '0;
            audio_last_ts_reg  <= '0;
            video_started_reg  <= 1'b0;
            audio_started_reg  <= 1'b0;
            sps_seen_reg       <= 1'b0;
            pps_seen_reg       <= 1'b0;
            frame_mode_reg     <= 1'b0;
            frame_is_video_reg <= 1'b0;
            chunk_left_reg     <= '0;
            frame_left_reg     <= '0;
        end else if (take) begin
            video_last_ts_reg  <= video_last_ts_next;
            audio_last_ts_reg  <= audio_last_ts_next;
            video_started_reg  <= video_started_next;
            audio_started_reg  <= audio_started_next;
            sps_seen_reg       <= sps_seen_next;
            pps_seen_reg       <= pps_seen_next;
            frame_mode_reg     <= frame_mode_next;
            frame_is_video_reg <= frame_is_video_next;
            chunk_left_reg     <= chunk_left_next;
            frame_left_reg     <= frame_left_next;
        end
    end

endmodule

>>> rtl/rmcf_serializer.sv
// ---------------------------------------------------------------------------
// RTMP media chunk framer output serializer
// Holds one byte burst and shifts it out one transaction per cycle while m_tready is high.
// ---------------------------------------------------------------------------
module rmcf_serializer (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  rmcf_pkg::burst_t burst,
    output logic             ser_ready,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,
    output logic             m_tlast
);

    logic [rmcf_pkg::COUNT_W-1:0] count_reg;
    rmcf_pkg::burst_bytes_t       bytes_reg;

    assign m_tvalid  = (count_reg != '0);
    assign m_tlast   = (count_reg == rmcf_pkg::COUNT_W'(1));
    assign m_tdata   = bytes_reg[0];
    assign ser_ready = (count_reg == '0) || (m_tlast && m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (load) begin
            count_reg <= burst.count;
        end else if (m_tvalid && m_tready) begin
            count_reg <= count_reg - rmcf_pkg::COUNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            bytes_reg <= burst.bytes;
        end else if (m_tvalid && m_tready) begin
            bytes_reg <= {8'd0, bytes_reg[rmcf_pkg::MAX_BURST-1:1]};
        end
    end

endmodule

>>> rtl/rtmp_media_chunk_framer.sv
// An accepted input is registered in the ingest stage, then loaded into the serializer
// once it is ready, before its first output byte appears. Output carries one payload
// byte per cycle while m_tready is high, plus a byte for each chunk separator; a frame
// start emits an 11-byte (audio) or 18-byte (video) burst, and the input stalls behind it.
// Reset is synchronous and active low: stream state clears and the configuration
// registers return to their reset values; no clearing pass follows.
// ---------------------------------------------------------------------------
// RTMP media chunk framer
// Turns AAC frames and H.264 NAL units, one byte per transaction, into
// RTMP chunk-stream bytes with message headers and chunk separators.
// ---------------------------------------------------------------------------
module rtmp_media_chunk_framer (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [rmcf_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [rmcf_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // data_byte[7:0], frame_length[31:8], pts[63:32], dts[95:64]
    input  logic [95:0]                        s_tdata,
    // is_video[0], first_byte[1]
    input  logic [1:0]                         s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // out_byte[7:0]
    output logic [7:0]                         m_tdata,
    output logic                               m_tlast
);

    rmcf_pkg::cfg_write_t cfg;
    rmcf_pkg::item_t      item;
    rmcf_pkg::burst_t     burst;
    logic                 item_valid;
    logic                 take;
    logic                 ser_ready;

    assign cfg.wr_en = cfg_wr_en;
    assign cfg.index = cfg_index;
    assign cfg.wdata = cfg_wdata;

    rmcf_ingest u_ingest (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    rmcf_framer u_framer (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item       (item),
        .ser_ready  (ser_ready),
        .take       (take),
        .burst      (burst)
    );

    rmcf_serializer u_serializer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (take),
        .burst     (burst),
        .ser_ready (ser_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

>>> rtl/rmcf_checker.sv
// ---------------------------------------------------------------------------
// RTMP media chunk framer port checker
// Watches the framer's stream ports over time and flags illegal behavior.
// ---------------------------------------------------------------------------
`include "rtmp_media_chunk_framer_assert.svh"

module rmcf_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    `RMCF_ASSERT_ALWAYS(a_reset_clears_output, aclk,
        !aresetn |=> !m_tvalid, "output valid after reset")
    `RMCF_ASSERT(a_burst_contiguous, aclk, aresetn,
        m_tvalid && m_tready && !m_tlast |=> m_tvalid, "gap in the middle of a burst")
    `RMCF_ASSERT(a_stall_only_when_busy, aclk, aresetn,
        !s_tready |-> m_tvalid, "input stalled while output idle")
    `RMCF_ASSERT(a_output_holds, aclk, aresetn,
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast),
        "stalled output transaction changed")

endmodule

bind rtmp_media_chunk_framer rmcf_checker u_checker (.*);
